[rtl/adam_pkg.sv]
// Shared types and constants for the fixed-point Adam update block.
// Used by adam_iter and adam_optimizer_update; depends on nothing else.
package adam_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_LEARNING_RATE = 2'd0,
		REG_FIRST_DECAY   = 2'd1,
		REG_SECOND_DECAY  = 2'd2,
		REG_STABILIZER    = 2'd3
	} cfg_reg_t;

	// One table entry: moments and shadow values of both phase values.
	typedef struct packed {
		logic signed [31:0] m2;
		logic signed [31:0] m1;
		logic [63:0]        v2;
		logic [63:0]        v1;
		logic signed [39:0] sh2;
		logic signed [39:0] sh1;
	} entry_t;

	// Request to the shared divide / square root iterator.
	typedef struct packed {
		logic        go;
		logic        sqrt;
		logic [48:0] rem0;
		logic [63:0] sh0;
		logic [48:0] den;
		logic [6:0]  cnt;
	} it_req_t;

	localparam logic [41:0] STEP_CAP = 42'h200_0000_0000;
	localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
	localparam logic [24:0] ONE_Q24  = 25'h100_0000;

endpackage

[rtl/adam_iter.sv]
// Shared iterative unit: restoring division or integer square root, one bit a cycle.
// Depends on adam_pkg for the request type.
module adam_iter import adam_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  it_req_t     req,
	output logic [63:0] quot,
	output logic        done
);

	logic        act_q;
	logic [6:0]  cnt_q;
	logic        sqrt_q;
	logic [48:0] rem_q;
	logic [63:0] sh_q;
	logic [63:0] q_q;
	logic [48:0] den_q;
	logic [49:0] trial;
	logic [49:0] sub_b;
	logic [49:0] diff;
	logic        ge;

	// A division shifts in one numerator bit, a square root two radicand bits.
	always_comb begin
		trial = sqrt_q ? {rem_q[47:0], sh_q[63:62]} : {rem_q, sh_q[63]};
		sub_b = sqrt_q ? {q_q[47:0], 2'b01} : {1'b0, den_q};
		ge    = trial >= sub_b;
		diff  = trial - sub_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.go) begin
			act_q <= 1'b1;
			cnt_q <= req.cnt;
		end else if (act_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			sqrt_q <= req.sqrt;
			rem_q  <= req.rem0;
			sh_q   <= req.sh0;
			den_q  <= req.den;
			q_q    <= '0;
		end else if (act_q && cnt_q != '0) begin
			rem_q <= ge ? diff[48:0] : trial[48:0];
			q_q   <= {q_q[62:0], ge};
			sh_q  <= sqrt_q ? {sh_q[61:0], 2'b00} : {sh_q[62:0], 1'b0};
		end
	end

	assign quot = q_q;
	assign done = act_q && (cnt_q == '0);

endmodule

[rtl/adam_optimizer_update.sv]
// Top level of the fixed-point Adam optimizer over a table of paired parameters.
// Depends on adam_pkg and instantiates adam_iter (shared divide / square root unit).
//
//   channel   handshake            payload
//   --------  -------------------  -------------------------------------------------
//   command   start / busy         action, param_index, new_step, grad_*, init_*
//   config    cfg_write            cfg_index, cfg_data
//   result    done (one cycle)     out_index, value_first, value_second
//
// A command transfer happens when start is high and busy is low. An index outside the
// table answers on the next cycle; a load passes through the write-back state before
// its result. In an update the bit-serial divide / square root unit runs a square root
// of the bias term and, for each of the two values, a 64-step, a 32-step, a 48-step and
// a 42-step pass, with work on the shared 33x33 multiplier around them.
// Reset restores the default configuration and sets the beta powers to all ones in Q0.32,
// just below one; table contents are undefined until loaded. The receiver cannot stall:
// done is high for exactly one cycle.
module adam_optimizer_update import adam_pkg::*; #(
	parameter int ENTRY_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [9:0]         param_index,
	input  logic               new_step,
	input  logic signed [31:0] grad_first,
	input  logic signed [31:0] grad_second,
	input  logic signed [15:0] init_first,
	input  logic signed [15:0] init_second,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output logic               done,
	output logic [9:0]         out_index,
	output logic signed [15:0] value_first,
	output logic signed [15:0] value_second
);

	localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_POW   = 11'b000_0000_0010,
		S_SQD   = 11'b000_0000_0100,
		S_MV    = 11'b000_0000_1000,
		S_MH    = 11'b000_0001_0000,
		S_SQV   = 11'b000_0010_0000,
		S_SV    = 11'b000_0100_0000,
		S_RAT   = 11'b000_1000_0000,
		S_LR    = 11'b001_0000_0000,
		S_UPD   = 11'b010_0000_0000,
		S_WRITE = 11'b100_0000_0000
	} state_t;

	// Configuration and beta powers.
	logic [23:0] lr_q, b1_q, b2_q;
	logic [15:0] stab_q;
	logic [31:0] p1_q, p2_q;

	// Control.
	state_t      st_q;
	logic [3:0]  ustep_q;
	logic        k_q;
	logic        it_run_q;
	logic        done_q;

	// Item and table data.
	logic [9:0]         idx_q;
	logic [AW-1:0]      addr_q;
	logic               ns_q;
	logic signed [31:0] g1_q, g2_q;
	entry_t             mem_q [ENTRY_COUNT];
	entry_t             rd_q;
	entry_t             ent_q;
	logic               mem_we;

	// Working registers.
	logic signed [65:0] prod_q;
	logic signed [65:0] acc_q;
	logic [63:0]        va_q, vb_q, gsq_q;
	logic signed [31:0] mn_q;
	logic [63:0]        vn_q;
	logic [16:0]        sqd_q;
	logic [63:0]        mh_q;
	logic [31:0]        isv_q;
	logic [48:0]        den_q;
	logic [41:0]        ratio_q;
	logic [41:0]        step_q;
	logic signed [15:0] vf_q, vs_q;

	// Combinational helpers.
	logic               accept;
	logic [12:0]        idx_ext;
	logic               in_range;
	logic signed [32:0] mul_a, mul_b;
	logic signed [31:0] m_cur, g_cur;
	logic [63:0]        v_cur;
	logic signed [39:0] sh_cur;
	logic [31:0]        gmag;
	logic [31:0]        mmag;
	logic [32:0]        d1, d2;
	logic [24:0]        c1, c2;
	logic               rat_big;
	logic [65:0]        acc_mag;
	logic [41:0]        acc_rnd;
	logic signed [31:0] m_sat;
	logic [64:0]        v_sum;
	logic signed [42:0] sh_sum;
	logic signed [39:0] sh_new;
	logic [49:0]        lr_shift;
	it_req_t            it_req;
	logic [63:0]        it_quot;
	logic               it_done;

	// Rounds a Q16.24 shadow value half away from zero and saturates it to 16 bits.
	function automatic logic signed [15:0] to_out16(input logic signed [39:0] s);
		logic [39:0] mag;
		logic [16:0] r;
		logic signed [15:0] res;
		mag = s[39] ? 40'(-s) : 40'(s);
		r   = 17'((41'(mag) + 41'h80_0000) >> 24);
		if (s[39]) begin
			res = (r >= 17'h8000) ? 16'sh8000 : 16'(-r);
		end else begin
			res = (r > 17'h7FFF) ? 16'sh7FFF : 16'(r);
		end
		return res;
	endfunction

	adam_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (it_req),
		.quot   (it_quot),
		.done   (it_done)
	);

	assign busy     = (st_q != S_IDLE);
	assign accept   = start && !busy;
	assign idx_ext  = {3'b000, param_index};
	assign in_range = idx_ext < 13'(ENTRY_COUNT);
	assign mem_we   = (st_q == S_WRITE);

	// Operands of the value being worked on.
	always_comb begin
		m_cur  = k_q ? rd_q.m2 : rd_q.m1;
		v_cur  = k_q ? rd_q.v2 : rd_q.v1;
		sh_cur = k_q ? rd_q.sh2 : rd_q.sh1;
		g_cur  = k_q ? g2_q : g1_q;
		gmag   = g_cur[31] ? 32'(-g_cur) : 32'(g_cur);
		mmag   = mn_q[31] ? 32'(-mn_q) : 32'(mn_q);
		d1     = ONE_Q32 - {1'b0, p1_q};
		d2     = ONE_Q32 - {1'b0, p2_q};
		c1     = ONE_Q24 - {1'b0, b1_q};
		c2     = ONE_Q24 - {1'b0, b2_q};
		rat_big = {3'b000, mh_q} >= {den_q, 18'd0};
	end

	// First moment: round the accumulated sum half away from zero, saturate to 32 bits.
	// Second moment: add both rounded terms, saturating on a carry out.
	always_comb begin
		acc_mag = acc_q[65] ? 66'(-acc_q) : 66'(acc_q);
		acc_rnd = 42'((acc_mag + 66'h80_0000) >> 24);
		if (acc_q[65]) begin
			m_sat = (acc_rnd >= 42'h8000_0000) ? 32'sh8000_0000 : 32'(-acc_rnd);
		end else begin
			m_sat = (acc_rnd > 42'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(acc_rnd);
		end
		v_sum = {1'b0, va_q} + {1'b0, vb_q};
	end

	// The step moves the shadow against the sign of the new first moment.
	always_comb begin
		if (mn_q[31]) begin
			sh_sum = 43'(sh_cur) + $signed({1'b0, step_q});
		end else begin
			sh_sum = 43'(sh_cur) - $signed({1'b0, step_q});
		end
		if (sh_sum > 43'sh7F_FFFF_FFFF) begin
			sh_new = 40'sh7F_FFFF_FFFF;
		end else if (sh_sum < -43'sh80_0000_0000) begin
			sh_new = 40'sh80_0000_0000;
		end else begin
			sh_new = sh_sum[39:0];
		end
		lr_shift = 50'(acc_q >>> 16);
	end

	// Shared multiplier operands, chosen by state and micro-step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			S_POW: begin
				if (ustep_q == 4'd0) begin
					mul_a = {1'b0, p1_q};
					mul_b = {9'd0, b1_q};
				end else begin
					mul_a = {1'b0, p2_q};
					mul_b = {9'd0, b2_q};
				end
			end
			S_MV: begin
				unique case (ustep_q)
					4'd0: begin
						mul_a = 33'(m_cur);
						mul_b = {9'd0, b1_q};
					end
					4'd1: begin
						mul_a = 33'(g_cur);
						mul_b = {8'd0, c1};
					end
					4'd2: begin
						mul_a = {1'b0, v_cur[63:32]};
						mul_b = {9'd0, b2_q};
					end
					4'd3: begin
						mul_a = {1'b0, v_cur[31:0]};
						mul_b = {9'd0, b2_q};
					end
					4'd4: begin
						mul_a = {1'b0, gmag};
						mul_b = {1'b0, gmag};
					end
					4'd6: begin
						mul_a = {1'b0, gsq_q[63:32]};
						mul_b = {8'd0, c2};
					end
					4'd7: begin
						mul_a = {1'b0, gsq_q[31:0]};
						mul_b = {8'd0, c2};
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			S_LR: begin
				if (ustep_q == 4'd0) begin
					mul_a = {12'd0, ratio_q[41:21]};
				end else begin
					mul_a = {12'd0, ratio_q[20:0]};
				end
				mul_b = {9'd0, lr_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Requests to the divide / square root unit; issued on the first cycle of a state.
	always_comb begin
		it_req = '0;
		if (!it_run_q) begin
			unique case (st_q)
				S_SQD: begin
					it_req.go   = 1'b1;
					it_req.sqrt = 1'b1;
					it_req.sh0  = {31'd0, d2};
					it_req.cnt  = 7'd32;
				end
				S_MH: begin
					it_req.go  = 1'b1;
					it_req.sh0 = {mmag, 32'd0};
					it_req.den = 49'(d1);
					it_req.cnt = 7'd64;
				end
				S_SQV: begin
					it_req.go   = 1'b1;
					it_req.sqrt = 1'b1;
					it_req.sh0  = vn_q;
					it_req.cnt  = 7'd32;
				end
				S_SV: begin
					it_req.go  = 1'b1;
					it_req.sh0 = {isv_q, 32'd0};
					it_req.den = 49'(sqd_q);
					it_req.cnt = 7'd48;
				end
				S_RAT: begin
					// A quotient that cannot fit below the cap skips the division.
					it_req.go   = (den_q != '0) && !rat_big;
					it_req.rem0 = 49'(mh_q[63:18]);
					it_req.sh0  = {mh_q[17:0], 46'd0};
					it_req.den  = den_q;
					it_req.cnt  = 7'd42;
				end
				default: it_req = '0;
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= 24'd65536;
			b1_q   <= 24'd15099494;
			b2_q   <= 24'd16760438;
			stab_q <= 16'd1;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEARNING_RATE: lr_q   <= cfg_data;
				REG_FIRST_DECAY:   b1_q   <= cfg_data;
				REG_SECOND_DECAY:  b2_q   <= cfg_data;
				REG_STABILIZER:    stab_q <= cfg_data[15:0];
			endcase
		end
	end

	// Parameter table: read when a command is taken, written back at the end.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr_q] <= ent_q;
		end
		if (accept) begin
			rd_q <= mem_q[idx_ext[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			ustep_q  <= '0;
			k_q      <= 1'b0;
			it_run_q <= 1'b0;
			done_q   <= 1'b0;
			p1_q     <= 32'hFFFF_FFFF;
			p2_q     <= 32'hFFFF_FFFF;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						ustep_q <= '0;
						k_q     <= 1'b0;
						if (!in_range) begin
							done_q <= 1'b1;
						end else if (!action) begin
							st_q <= S_WRITE;
						end else begin
							st_q <= S_POW;
						end
					end
				end
				S_POW: begin
					if (!ns_q) begin
						st_q <= S_SQD;
					end else begin
						ustep_q <= ustep_q + 4'd1;
						if (ustep_q == 4'd1) begin
							p1_q <= prod_q[55:24];
						end else if (ustep_q == 4'd2) begin
							p2_q    <= prod_q[55:24];
							st_q    <= S_SQD;
							ustep_q <= '0;
						end
					end
				end
				S_SQD, S_MH, S_SQV, S_SV: begin
					if (!it_run_q) begin
						it_run_q <= 1'b1;
					end else if (it_done) begin
						it_run_q <= 1'b0;
						unique case (st_q)
							S_SQD: begin
								st_q    <= S_MV;
								ustep_q <= '0;
							end
							S_MH:    st_q <= S_SQV;
							S_SQV:   st_q <= S_SV;
							default: st_q <= S_RAT;
						endcase
					end
				end
				S_MV: begin
					ustep_q <= ustep_q + 4'd1;
					if (ustep_q == 4'd9) begin
						st_q <= S_MH;
					end
				end
				S_RAT: begin
					if (!it_run_q) begin
						if (den_q == '0) begin
							st_q <= S_UPD;
						end else if (rat_big) begin
							st_q    <= S_LR;
							ustep_q <= '0;
						end else begin
							it_run_q <= 1'b1;
						end
					end else if (it_done) begin
						it_run_q <= 1'b0;
						st_q     <= S_LR;
						ustep_q  <= '0;
					end
				end
				S_LR: begin
					ustep_q <= ustep_q + 4'd1;
					if (ustep_q == 4'd3) begin
						st_q <= S_UPD;
					end
				end
				S_UPD: begin
					ustep_q <= '0;
					if (!k_q) begin
						k_q  <= 1'b1;
						st_q <= S_MV;
					end else begin
						st_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					done_q <= 1'b1;
					st_q   <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they follow the sequencer and need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= param_index;
			addr_q <= idx_ext[AW-1:0];
			ns_q   <= new_step;
			g1_q   <= grad_first;
			g2_q   <= grad_second;
			ent_q.m1  <= '0;
			ent_q.m2  <= '0;
			ent_q.v1  <= '0;
			ent_q.v2  <= '0;
			ent_q.sh1 <= {init_first, 24'd0};
			ent_q.sh2 <= {init_second, 24'd0};
			if (!in_range) begin
				vf_q <= '0;
				vs_q <= '0;
			end
		end
		if (st_q == S_MV) begin
			unique case (ustep_q)
				4'd1: acc_q <= prod_q;
				4'd2: acc_q <= acc_q + prod_q;
				4'd3: va_q  <= {prod_q[55:0], 8'd0};
				4'd4: va_q  <= va_q + 64'((prod_q[56:0] + 57'h80_0000) >> 24);
				4'd5: gsq_q <= prod_q[63:0];
				4'd7: vb_q  <= {prod_q[55:0], 8'd0};
				4'd8: vb_q  <= vb_q + 64'((prod_q[57:0] + 58'h80_0000) >> 24);
				4'd9: begin
					mn_q <= m_sat;
					vn_q <= v_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : v_sum[63:0];
				end
				default: ;
			endcase
		end
		if (it_run_q && it_done) begin
			unique case (st_q)
				S_SQD:   sqd_q <= it_quot[16:0];
				S_MH:    mh_q  <= it_quot;
				S_SQV:   isv_q <= it_quot[31:0];
				S_SV:    den_q <= 49'(it_quot[47:0]) + 49'(stab_q);
				S_RAT:   ratio_q <= (it_quot[41:0] > STEP_CAP) ? STEP_CAP : it_quot[41:0];
				default: ;
			endcase
		end
		if (st_q == S_RAT && !it_run_q) begin
			if (den_q == '0) begin
				step_q <= '0;
			end else if (rat_big) begin
				ratio_q <= STEP_CAP;
			end
		end
		if (st_q == S_LR) begin
			unique case (ustep_q)
				4'd1: acc_q <= prod_q <<< 21;
				4'd2: acc_q <= acc_q + prod_q;
				4'd3: step_q <= (lr_shift > 50'(STEP_CAP)) ? STEP_CAP : lr_shift[41:0];
				default: ;
			endcase
		end
		if (st_q == S_UPD) begin
			if (!k_q) begin
				ent_q.m1  <= mn_q;
				ent_q.v1  <= vn_q;
				ent_q.sh1 <= sh_new;
			end else begin
				ent_q.m2  <= mn_q;
				ent_q.v2  <= vn_q;
				ent_q.sh2 <= sh_new;
			end
		end
		if (st_q == S_WRITE) begin
			vf_q <= to_out16(ent_q.sh1);
			vs_q <= to_out16(ent_q.sh2);
		end
	end

	assign done         = done_q;
	assign out_index    = idx_q;
	assign value_first  = vf_q;
	assign value_second = vs_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy) else $error("result strobe while busy");
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done_q)) else $error("accepted command made no progress");
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WRITE) |=> (done_q && st_q == S_IDLE)) else $error("write-back gave no result");
	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_UPD && k_q) |=> (st_q == S_WRITE)) else $error("second value did not finish");
`endif

endmodule
